### rtl/rv32ie_pkg.sv
// Package: constants, opcodes and shared types for the RV32I execute block.
`timescale 1ns / 1ps
package rv32ie_pkg;

    localparam int MEM_BYTES = 1024;
    localparam int MEM_ROWS  = MEM_BYTES / 4;
    localparam int ROW_W     = $clog2(MEM_ROWS);
    localparam int NREGS     = 32;
    localparam int REG_W     = $clog2(NREGS);

    localparam logic [31:0] RESET_PC = 32'h0000_0100;

    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_B    = 3'd0;
    localparam logic [2:0] F3_H    = 3'd1;
    localparam logic [2:0] F3_W    = 3'd2;
    localparam logic [2:0] F3_BU   = 3'd4;
    localparam logic [2:0] F3_HU   = 3'd5;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    typedef struct packed {
        logic [31:0]      npc;
        logic             wr;
        logic [REG_W-1:0] rd;
        logic [31:0]      val;
        logic             ill;
        logic             is_load;
        logic             is_store;
        logic [1:0]       st_size;
        logic [31:0]      addr;
        logic [31:0]      wdata;
    } t_exec;

    typedef struct packed {
        logic        rd_en;
        logic        wr_en;
        logic [1:0]  size;
        logic [31:0] addr;
        logic [31:0] wdata;
    } t_mreq;

endpackage

### rtl/rv32ie_if.sv
// Interfaces: instruction request channel and result channel.
`timescale 1ns / 1ps
interface rv32ie_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr_word;
    modport source (output valid, output instr_word, input ready);
    modport sink   (input valid, input instr_word, output ready);
endinterface

interface rv32ie_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] executed_pc;
    logic [31:0] next_pc;
    logic        dest_written;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        illegal;
    modport source (output valid, output executed_pc, output next_pc, output dest_written,
                    output dest_index, output dest_value, output illegal, input ready);
    modport sink   (input valid, input executed_pc, input next_pc, input dest_written,
                    input dest_index, input dest_value, input illegal, output ready);
endinterface

### rtl/rv32ie_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rv32ie_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

### rtl/rv32ie_dmem.sv
// Data memory: four byte banks, misaligned byte rotation and clear sweep after reset.
`timescale 1ns / 1ps
module rv32ie_dmem import rv32ie_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mreq       i_req,
    output logic [31:0] o_rdata,
    output logic        o_busy
);
    logic [ROW_W-1:0] r_clr_row;
    logic             r_clr;
    logic [1:0]       r_lo;
    logic [7:0]       q [4];
    logic [7:0]       lb [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_row <= '0;
        end else if (r_clr) begin
            r_clr_row <= r_clr_row + 1'b1;
            if (r_clr_row == ROW_W'(MEM_ROWS - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_lo <= i_req.addr[1:0];
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [1:0]       off;
        logic [31:0]      sum;
        logic             we;
        logic [ROW_W-1:0] row;
        logic [7:0]       wd;

        assign off = 2'(k) - i_req.addr[1:0];
        assign sum = i_req.addr + {30'd0, off};
        assign we  = i_req.wr_en && ({1'b0, off} < (3'd1 << i_req.size));
        assign row = sum[ROW_W+1:2];
        assign wd  = i_req.wdata[8*off +: 8];

        rv32ie_ram #(.W(8), .D(MEM_ROWS)) u_bank (
            .i_clk  (i_clk),
            .i_we   (r_clr || we),
            .i_waddr(r_clr ? r_clr_row : row),
            .i_wdata(r_clr ? 8'd0 : wd),
            .i_re   (i_req.rd_en),
            .i_raddr(row),
            .o_rdata(q[k])
        );

        assign lb[k] = q[2'(r_lo + 2'(k))];
    end

    assign o_rdata = {lb[3], lb[2], lb[1], lb[0]};
    assign o_busy  = r_clr;
endmodule

### rtl/rv32ie_exec.sv
// Execute logic: decode, ALU, branch, address and load formatting for one instruction.
`timescale 1ns / 1ps
module rv32ie_exec import rv32ie_pkg::*; (
    input  logic [31:0] i_instr,
    input  logic [31:0] i_pc,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_ld,
    input  logic        i_halted,
    output t_exec       o_ex
);
    logic [6:0]  opc;
    logic [6:0]  f7;
    logic [2:0]  f3;
    logic [4:0]  sh;
    logic [31:0] immi, imms, immb, immj, immu, pc4;
    logic        lt, ltu;
    t_exec       ex;

    assign opc  = i_instr[6:0];
    assign f3   = i_instr[14:12];
    assign f7   = i_instr[31:25];
    assign sh   = i_instr[24:20];
    assign immi = {{20{i_instr[31]}}, i_instr[31:20]};
    assign imms = {{20{i_instr[31]}}, i_instr[31:25], i_instr[11:7]};
    assign immb = {{19{i_instr[31]}}, i_instr[31], i_instr[7], i_instr[30:25],
                   i_instr[11:8], 1'b0};
    assign immj = {{11{i_instr[31]}}, i_instr[31], i_instr[19:12], i_instr[20],
                   i_instr[30:21], 1'b0};
    assign immu = {i_instr[31:12], 12'd0};
    assign pc4  = i_pc + 32'd4;

    always_comb begin
        ex          = '0;
        ex.npc      = pc4;
        ex.rd       = i_instr[11:7];
        ex.addr     = i_a + immi;
        ex.wdata    = i_b;
        ex.st_size  = f3[1:0];
        lt          = 1'b0;
        ltu         = 1'b0;
        if (i_halted) begin
            ex.npc = i_pc;
            ex.ill = 1'b1;
        end else begin
            unique case (opc)
                OPC_OP: begin
                    lt  = $signed(i_a) < $signed(i_b);
                    ltu = i_a < i_b;
                    ex.wr = 1'b1;
                    if (f7 == F7_BASE) begin
                        case (f3)
                            F3_ADD:  ex.val = i_a + i_b;
                            F3_SLL:  ex.val = i_a << i_b[4:0];
                            F3_SLT:  ex.val = {31'd0, lt};
                            F3_SLTU: ex.val = {31'd0, ltu};
                            F3_XOR:  ex.val = i_a ^ i_b;
                            F3_SR:   ex.val = i_a >> i_b[4:0];
                            F3_OR:   ex.val = i_a | i_b;
                            default: ex.val = i_a & i_b;
                        endcase
                    end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                        ex.val = i_a - i_b;
                    end else if (f7 == F7_ALT && f3 == F3_SR) begin
                        ex.val = $unsigned($signed(i_a) >>> i_b[4:0]);
                    end else begin
                        ex.wr = 1'b0;
                    end
                end
                OPC_OPIMM: begin
                    lt  = $signed(i_a) < $signed(immi);
                    ltu = i_a < immi;
                    ex.wr = 1'b1;
                    case (f3)
                        F3_ADD:  ex.val = i_a + immi;
                        F3_SLL: begin
                            if (f7 == F7_BASE) ex.val = i_a << sh;
                            else ex.wr = 1'b0;
                        end
                        F3_SLT:  ex.val = {31'd0, lt};
                        F3_SLTU: ex.val = {31'd0, ltu};
                        F3_XOR:  ex.val = i_a ^ immi;
                        F3_SR: begin
                            if (f7 == F7_BASE) ex.val = i_a >> sh;
                            else if (f7 == F7_ALT) ex.val = $unsigned($signed(i_a) >>> sh);
                            else ex.wr = 1'b0;
                        end
                        F3_OR:   ex.val = i_a | immi;
                        default: ex.val = i_a & immi;
                    endcase
                end
                OPC_LOAD: begin
                    ex.is_load = 1'b1;
                    ex.wr      = 1'b1;
                    case (f3)
                        F3_B:    ex.val = {{24{i_ld[7]}}, i_ld[7:0]};
                        F3_H:    ex.val = {{16{i_ld[15]}}, i_ld[15:0]};
                        F3_W:    ex.val = i_ld;
                        F3_BU:   ex.val = {24'd0, i_ld[7:0]};
                        F3_HU:   ex.val = {16'd0, i_ld[15:0]};
                        default: ex.wr  = 1'b0;
                    endcase
                end
                OPC_STORE: begin
                    ex.addr     = i_a + imms;
                    ex.is_store = (f3 == F3_B) || (f3 == F3_H) || (f3 == F3_W);
                end
                OPC_BRANCH: begin
                    lt  = $signed(i_a) < $signed(i_b);
                    ltu = i_a < i_b;
                    case (f3)
                        F3_BEQ:  if (i_a == i_b) ex.npc = i_pc + immb;
                        F3_BNE:  if (i_a != i_b) ex.npc = i_pc + immb;
                        F3_BLT:  if (lt) ex.npc = i_pc + immb;
                        F3_BGE:  if (!lt) ex.npc = i_pc + immb;
                        F3_BLTU: if (ltu) ex.npc = i_pc + immb;
                        F3_BGEU: if (!ltu) ex.npc = i_pc + immb;
                        default: ex.npc = pc4;
                    endcase
                end
                OPC_JAL: begin
                    ex.wr  = 1'b1;
                    ex.val = pc4;
                    ex.npc = i_pc + immj;
                end
                OPC_JALR: begin
                    if (f3 == F3_ADD) begin
                        ex.wr  = 1'b1;
                        ex.val = pc4;
                        ex.npc = (i_a + immi) & ~32'd1;
                    end
                end
                OPC_LUI: begin
                    ex.wr  = 1'b1;
                    ex.val = immu;
                end
                OPC_AUIPC: begin
                    ex.wr  = 1'b1;
                    ex.val = i_pc + immu;
                end
                OPC_SYSTEM: ex.wr = 1'b0;
                default: begin
                    ex.ill = 1'b1;
                    ex.npc = i_pc;
                end
            endcase
        end
        if (ex.rd == '0) begin
            ex.wr = 1'b0;
        end
        if (!ex.wr) begin
            ex.rd  = '0;
            ex.val = '0;
        end
    end

    assign o_ex = ex;
endmodule

### rtl/rv32i_instruction_execute.sv
// Top level: RV32I execute block with register file, data memory and APB config port.
// The execute register holds an accepted request; its result is registered at the output.
// Throughput: one instruction per cycle while the result channel and data memory do not stall;
// a load holds the execute register for the registered data memory read.
// Reset: registers read zero, pc = 0x100; the data memory is swept to zero after reset,
// with no requests taken (config writes still are).
`timescale 1ns / 1ps
module rv32i_instruction_execute import rv32ie_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rv32ie_in_if.sink   i_instr,
    rv32ie_out_if.source o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [31:0]      r_start, r_pc, r_e_instr, r_bval1, r_bval2;
    logic             r_e_vld, r_ld_rdy, r_halted, r_byp1, r_byp2, r_v1, r_v2;
    logic [NREGS-1:0] r_rf_vld;
    logic             r_o_vld;
    logic [31:0]      r_o_epc, r_o_npc, r_o_val;
    logic             r_o_wr, r_o_ill;
    logic [4:0]       r_o_rd;

    logic             in_acc, out_free, e_go, ld_issue, cfg_wr, mem_busy, rf_we;
    logic [REG_W-1:0] rs1, rs2;
    logic [31:0]      q1, q2, a, b, ld_data;
    t_exec            ex;
    t_mreq            mreq;

    assign rs1      = i_instr.instr_word[19:15];
    assign rs2      = i_instr.instr_word[24:20];
    assign in_acc   = i_instr.valid && i_instr.ready;
    assign out_free = !r_o_vld || o_result.ready;
    assign e_go     = r_e_vld && out_free && (!ex.is_load || r_ld_rdy);
    assign ld_issue = r_e_vld && ex.is_load && !r_ld_rdy;
    assign rf_we    = e_go && ex.wr;
    assign i_instr.ready = !mem_busy && (!r_e_vld || e_go);

    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : r_start;

    rv32ie_ram #(.W(32), .D(NREGS)) u_rf1 (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(ex.rd), .i_wdata(ex.val),
        .i_re(in_acc), .i_raddr(rs1), .o_rdata(q1)
    );
    rv32ie_ram #(.W(32), .D(NREGS)) u_rf2 (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(ex.rd), .i_wdata(ex.val),
        .i_re(in_acc), .i_raddr(rs2), .o_rdata(q2)
    );

    assign a = r_byp1 ? r_bval1 : (r_v1 ? q1 : 32'd0);
    assign b = r_byp2 ? r_bval2 : (r_v2 ? q2 : 32'd0);

    rv32ie_exec u_exec (
        .i_instr (r_e_instr),
        .i_pc    (r_pc),
        .i_a     (a),
        .i_b     (b),
        .i_ld    (ld_data),
        .i_halted(r_halted),
        .o_ex    (ex)
    );

    always_comb begin
        mreq.rd_en = ld_issue;
        mreq.wr_en = e_go && ex.is_store;
        mreq.size  = ex.st_size;
        mreq.addr  = ex.addr;
        mreq.wdata = ex.wdata;
    end

    rv32ie_dmem u_dmem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mreq),
        .o_rdata(ld_data),
        .o_busy (mem_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= RESET_PC;
            r_pc     <= RESET_PC;
            r_e_vld  <= 1'b0;
            r_ld_rdy <= 1'b0;
            r_halted <= 1'b0;
            r_rf_vld <= '0;
            r_o_vld  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_start <= pwdata;
                r_pc    <= pwdata;
            end else if (e_go) begin
                r_pc <= ex.npc;
            end
            if (e_go) begin
                r_halted <= r_halted || ex.ill;
                r_ld_rdy <= 1'b0;
            end else if (ld_issue) begin
                r_ld_rdy <= 1'b1;
            end
            if (rf_we) begin
                r_rf_vld[ex.rd] <= 1'b1;
            end
            if (in_acc) begin
                r_e_vld <= 1'b1;
            end else if (e_go) begin
                r_e_vld <= 1'b0;
            end
            if (e_go) begin
                r_o_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_e_instr <= i_instr.instr_word;
            r_byp1    <= rf_we && (ex.rd == rs1);
            r_byp2    <= rf_we && (ex.rd == rs2);
            r_bval1   <= ex.val;
            r_bval2   <= ex.val;
            r_v1      <= r_rf_vld[rs1];
            r_v2      <= r_rf_vld[rs2];
        end
        if (e_go) begin
            r_o_epc <= r_pc;
            r_o_npc <= ex.npc;
            r_o_wr  <= ex.wr;
            r_o_rd  <= ex.rd;
            r_o_val <= ex.val;
            r_o_ill <= ex.ill;
        end
    end

    assign o_result.valid        = r_o_vld;
    assign o_result.executed_pc  = r_o_epc;
    assign o_result.next_pc      = r_o_npc;
    assign o_result.dest_written = r_o_wr;
    assign o_result.dest_index   = r_o_rd;
    assign o_result.dest_value   = r_o_val;
    assign o_result.illegal      = r_o_ill;
endmodule
